// ----- src/bfma_pkg.sv -----
// Shared constants, codes and types of the best-fit allocator.
package bfma_pkg;

  localparam int MAX_PROCS   = 32;
  localparam int ADDR_BITS   = 20;
  localparam int SIZE_W      = ADDR_BITS + 1;
  localparam int ID_W        = 16;
  localparam int TIME_W      = 32;
  localparam int K_BITS      = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_BITS    = $clog2(MAX_PROCS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QC_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SIZE_W-1:0] MEM_MAX = SIZE_W'(1) << ADDR_BITS;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_COMPACT = 2'd2;
  localparam logic [1:0] REQ_TICK    = 2'd3;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOSPACE  = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_DUP      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_COMPACT,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [ID_W-1:0]     id;
    logic [SIZE_W-1:0]   size;
    logic [TIME_W-1:0]   operand;
    logic                size_zero;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]      owner;
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_W-1:0]    len;
    logic [TIME_W-1:0]    tleft;
    logic                 flag;
  } entry_t;

endpackage

// ----- src/bfma_if.sv -----
// Channel interfaces: request, response and configuration write.
interface bfma_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [bfma_pkg::ID_W-1:0]     proc_id;
  logic [bfma_pkg::SIZE_W-1:0]   proc_size;
  logic [bfma_pkg::TIME_W-1:0]   lifetime;
  logic [bfma_pkg::TIME_W-1:0]   tick_amount;
  modport source(output valid, req_type, proc_id, proc_size, lifetime, tick_amount,
                 input ready);
  modport sink(input valid, req_type, proc_id, proc_size, lifetime, tick_amount,
               output ready);
endinterface

interface bfma_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [bfma_pkg::ADDR_BITS-1:0] address;
  logic [bfma_pkg::ID_W-1:0]      expired_id;
  logic [bfma_pkg::SIZE_W-1:0]    free_space;
  logic                           compacted;
  logic                           last;
  modport source(output valid, status, address, expired_id, free_space, compacted, last,
                 input ready);
  modport sink(input valid, status, address, expired_id, free_space, compacted, last,
               output ready);
endinterface

interface bfma_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bfma_pkg::SIZE_W-1:0] memory_size;
  modport source(output valid, memory_size, input ready);
  modport sink(input valid, memory_size, output ready);
endinterface

// ----- src/best_fit_memory_allocator.sv -----
// Top level of the best-fit allocator.
// Throughput: one request at a time in the engine, bounded by the one-entry-per-cycle
// table scan, which the expire pass holds while the result register is full; a
// two-deep command queue lets requests arrive during execution.
// Reset: empty table, memory_size 2^ADDR_BITS, all free; no clearing pass.
module best_fit_memory_allocator (
  input  logic        clk,
  input  logic        rst,
  bfma_cfg_if.sink    cfg,
  bfma_req_if.sink    req,
  bfma_rsp_if.source  rsp
);

  logic            push_valid;
  logic            push_ready;
  bfma_pkg::cmd_t  push_cmd;
  logic            pop_valid;
  logic            pop_ready;
  bfma_pkg::cmd_t  pop_cmd;

  bfma_front u_front (
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  bfma_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  bfma_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .rsp       (rsp)
  );

endmodule

// ----- src/bfma_front.sv -----
// Front end: accept requests and classify them into commands.
module bfma_front (
  bfma_req_if.sink        req,
  output logic            push_valid,
  input  logic            push_ready,
  output bfma_pkg::cmd_t  push_cmd
);

  always_comb begin
    push_cmd.id        = req.proc_id;
    push_cmd.size      = req.proc_size;
    push_cmd.size_zero = (req.proc_size == '0);
    push_cmd.operand   = req.lifetime;
    case (req.req_type)
      bfma_pkg::REQ_ALLOC:   push_cmd.op = bfma_pkg::OP_ALLOC;
      bfma_pkg::REQ_FREE:    push_cmd.op = bfma_pkg::OP_FREE;
      bfma_pkg::REQ_COMPACT: push_cmd.op = bfma_pkg::OP_COMPACT;
      default: begin
        push_cmd.op      = bfma_pkg::OP_TICK;
        push_cmd.operand = req.tick_amount;
      end
    endcase
  end

  assign push_valid = req.valid;
  assign req.ready  = push_ready;

endmodule

// ----- src/bfma_queue.sv -----
// Command queue between front end and execution engine.
module bfma_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  bfma_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output bfma_pkg::cmd_t  pop_cmd
);

  bfma_pkg::cmd_t                slots [bfma_pkg::QUEUE_DEPTH];
  logic [bfma_pkg::QP_BITS-1:0]  wr_ptr;
  logic [bfma_pkg::QP_BITS-1:0]  rd_ptr;
  logic [bfma_pkg::QC_BITS-1:0]  count;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = (count != bfma_pkg::QC_BITS'(bfma_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/bfma_back.sv -----
// Execution engine: address-sorted allocation table, scans and result register.
module bfma_back (
  input  logic            clk,
  input  logic            rst,
  bfma_cfg_if.sink        cfg,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  bfma_pkg::cmd_t  pop_cmd,
  bfma_rsp_if.source      rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_LAST,
    S_TOP,
    S_SEND,
    S_EXPIRE
  } state_t;

  state_t                            state;
  bfma_pkg::cmd_t                    cmd;
  bfma_pkg::entry_t                  tbl [bfma_pkg::MAX_PROCS];
  logic [bfma_pkg::CNT_BITS-1:0]     k;
  logic [bfma_pkg::CNT_BITS-1:0]     n;
  logic [bfma_pkg::CNT_BITS-1:0]     best_k;
  logic [bfma_pkg::SIZE_W-1:0]       cur;
  logic [bfma_pkg::SIZE_W-1:0]       best_sz;
  logic [bfma_pkg::ADDR_BITS-1:0]    best_at;
  logic                              found;
  logic                              hit;
  logic [bfma_pkg::SIZE_W-1:0]       hit_len;
  logic [bfma_pkg::SIZE_W-1:0]       top_end;
  logic [bfma_pkg::SIZE_W-1:0]       mem_size;
  logic [bfma_pkg::SIZE_W-1:0]       free_total;
  bfma_pkg::status_t                 status;
  logic [bfma_pkg::ADDR_BITS-1:0]    addr;

  logic                              oval;
  logic [1:0]                        o_status;
  logic [bfma_pkg::ADDR_BITS-1:0]    o_addr;
  logic [bfma_pkg::ID_W-1:0]         o_eid;
  logic [bfma_pkg::SIZE_W-1:0]       o_free;
  logic                              o_cmpct;
  logic                              o_last;
  logic                              o_load;

  logic [bfma_pkg::K_BITS-1:0]       k_idx;
  bfma_pkg::entry_t                  rd;
  bfma_pkg::entry_t                  wr_entry;
  bfma_pkg::entry_t                  ins_entry;
  logic                              at_end;
  logic                              slot_free;
  logic [bfma_pkg::SIZE_W-1:0]       end_v;
  logic [bfma_pkg::SIZE_W-1:0]       gap;
  logic [bfma_pkg::SIZE_W-1:0]       rd_end;
  logic                              fits;
  logic                              expire;
  logic                              cmpct;
  logic                              tbl_ins;
  logic                              tbl_rem;
  logic                              tbl_wr;
  logic                              is_full;
  logic [bfma_pkg::SIZE_W-1:0]       cfg_val;

  assign k_idx     = k[bfma_pkg::K_BITS-1:0];
  assign rd        = tbl[k_idx];
  assign at_end    = (k == n);
  assign slot_free = !oval || rsp.ready;
  assign rd_end    = bfma_pkg::SIZE_W'(rd.start) + rd.len;
  assign end_v     = at_end ? mem_size : bfma_pkg::SIZE_W'(rd.start);
  assign gap       = end_v - cur;
  assign fits      = (gap >= cmd.size) && (!found || gap < best_sz);
  assign expire    = (cmd.operand >= rd.tleft);
  assign cmpct     = (top_end == (mem_size - free_total));
  assign is_full   = (n == bfma_pkg::CNT_BITS'(bfma_pkg::MAX_PROCS));
  assign pop_ready = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready = (state == S_IDLE);
  assign o_load    = slot_free
                     && ((state == S_SEND) || ((state == S_EXPIRE) && (at_end || rd.flag)));

  always_comb begin
    if (cfg.memory_size == '0) begin
      cfg_val = bfma_pkg::SIZE_W'(1);
    end else if (cfg.memory_size > bfma_pkg::MEM_MAX) begin
      cfg_val = bfma_pkg::MEM_MAX;
    end else begin
      cfg_val = cfg.memory_size;
    end
  end

  always_comb begin
    tbl_ins = (state == S_DECIDE) && (cmd.op == bfma_pkg::OP_ALLOC) && !hit && !is_full
              && !cmd.size_zero && found;
    tbl_rem = ((state == S_DECIDE) && (cmd.op == bfma_pkg::OP_FREE) && hit)
              || ((state == S_EXPIRE) && !at_end && rd.flag && slot_free);
    tbl_wr  = (state == S_SCAN) && !at_end
              && ((cmd.op == bfma_pkg::OP_COMPACT) || (cmd.op == bfma_pkg::OP_TICK));
    wr_entry = rd;
    if (cmd.op == bfma_pkg::OP_COMPACT) begin
      wr_entry.start = cur[bfma_pkg::ADDR_BITS-1:0];
    end else if (expire) begin
      wr_entry.flag = 1'b1;
    end else begin
      wr_entry.tleft = rd.tleft - cmd.operand;
      wr_entry.flag  = 1'b0;
    end
    ins_entry.owner = cmd.id;
    ins_entry.start = best_at;
    ins_entry.len   = cmd.size;
    ins_entry.tleft = cmd.operand;
    ins_entry.flag  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (tbl_ins) begin
      for (int j = 1; j < bfma_pkg::MAX_PROCS; j++) begin
        if (bfma_pkg::CNT_BITS'(j) > best_k) begin
          tbl[j] <= tbl[j-1];
        end
      end
      tbl[best_k[bfma_pkg::K_BITS-1:0]] <= ins_entry;
    end else if (tbl_rem) begin
      for (int j = 0; j < bfma_pkg::MAX_PROCS - 1; j++) begin
        if (bfma_pkg::CNT_BITS'(j) >= k) begin
          tbl[j] <= tbl[j+1];
        end
      end
    end else if (tbl_wr) begin
      tbl[k_idx] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      n          <= '0;
      mem_size   <= bfma_pkg::MEM_MAX;
      free_total <= bfma_pkg::MEM_MAX;
      oval       <= 1'b0;
    end else begin
      if (oval && rsp.ready && !o_load) begin
        oval <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg.valid) begin
            mem_size   <= cfg_val;
            free_total <= cfg_val;
            n          <= '0;
          end else if (pop_valid) begin
            cmd     <= pop_cmd;
            k       <= '0;
            cur     <= '0;
            found   <= 1'b0;
            hit     <= 1'b0;
            top_end <= '0;
            addr    <= '0;
            status  <= bfma_pkg::STAT_OK;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          case (cmd.op)
            bfma_pkg::OP_ALLOC: begin
              if (fits) begin
                found   <= 1'b1;
                best_sz <= gap;
                best_k  <= k;
                best_at <= cur[bfma_pkg::ADDR_BITS-1:0];
              end
              if (at_end) begin
                state <= S_DECIDE;
              end else begin
                if (rd.owner == cmd.id) begin
                  hit <= 1'b1;
                end
                cur <= rd_end;
                k   <= k + 1'b1;
              end
            end
            bfma_pkg::OP_FREE: begin
              if (at_end) begin
                state <= S_DECIDE;
              end else if (rd.owner == cmd.id) begin
                hit     <= 1'b1;
                hit_len <= rd.len;
                state   <= S_DECIDE;
              end else begin
                k <= k + 1'b1;
              end
            end
            bfma_pkg::OP_COMPACT: begin
              if (at_end) begin
                state <= S_LAST;
              end else begin
                cur <= cur + rd.len;
                k   <= k + 1'b1;
              end
            end
            default: begin
              if (at_end) begin
                k     <= '0;
                state <= S_EXPIRE;
              end else begin
                if (expire) begin
                  free_total <= free_total + rd.len;
                end else begin
                  top_end <= rd_end;
                end
                k <= k + 1'b1;
              end
            end
          endcase
        end
        S_DECIDE: begin
          if (cmd.op == bfma_pkg::OP_ALLOC) begin
            if (hit) begin
              status <= bfma_pkg::STAT_DUP;
            end else if (tbl_ins) begin
              n          <= n + 1'b1;
              free_total <= free_total - cmd.size;
              addr       <= best_at;
            end else begin
              status <= bfma_pkg::STAT_NOSPACE;
            end
          end else if (hit) begin
            n          <= n - 1'b1;
            free_total <= free_total + hit_len;
          end else begin
            status <= bfma_pkg::STAT_NOTFOUND;
          end
          state <= S_LAST;
        end
        S_LAST: begin
          k     <= n - 1'b1;
          state <= S_TOP;
        end
        S_TOP: begin
          top_end <= (n == '0) ? '0 : rd_end;
          state   <= S_SEND;
        end
        S_SEND: begin
          if (slot_free) begin
            oval     <= 1'b1;
            o_status <= status;
            o_addr   <= addr;
            o_eid    <= '0;
            o_free   <= free_total;
            o_cmpct  <= cmpct;
            o_last   <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_EXPIRE: begin
          if (at_end) begin
            if (slot_free) begin
              oval     <= 1'b1;
              o_status <= bfma_pkg::STAT_OK;
              o_addr   <= '0;
              o_eid    <= '0;
              o_free   <= free_total;
              o_cmpct  <= cmpct;
              o_last   <= 1'b1;
              state    <= S_IDLE;
            end
          end else if (rd.flag) begin
            if (slot_free) begin
              oval     <= 1'b1;
              o_status <= bfma_pkg::STAT_OK;
              o_addr   <= '0;
              o_eid    <= rd.owner;
              o_free   <= free_total;
              o_cmpct  <= cmpct;
              o_last   <= 1'b0;
              n        <= n - 1'b1;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid      = oval;
  assign rsp.status     = o_status;
  assign rsp.address    = o_addr;
  assign rsp.expired_id = o_eid;
  assign rsp.free_space = o_free;
  assign rsp.compacted  = o_cmpct;
  assign rsp.last       = o_last;

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= mem_size) else $error("free space exceeds memory size");
  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready && !cfg.valid) |=> state == S_SCAN)
    else $error("popped command not started");
  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    tbl_ins |-> (n < bfma_pkg::CNT_BITS'(bfma_pkg::MAX_PROCS)))
    else $error("insert into full table");
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    tbl_rem |-> (k < n)) else $error("remove beyond table fill");

endmodule

// ----- tb/tb_best_fit_memory_allocator.sv -----
// Self-checking testbench for the best-fit allocator: random and directed requests
// against a built-in predictor.
module tb_best_fit_memory_allocator;
  import bfma_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t              status;
    logic [ADDR_BITS-1:0] address;
    logic [ID_W-1:0]      expired_id;
    logic [SIZE_W-1:0]    free_space;
    logic                 compacted;
    logic                 last;
  } rsp_item_t;

  typedef struct {
    logic [1:0]        kind;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] life;
    logic [TIME_W-1:0] tick;
  } req_item_t;

  class alloc_scoreboard;
    bit                slot_used [MAX_PROCS];
    logic [ID_W-1:0]   slot_owner[MAX_PROCS];
    logic [SIZE_W:0]   slot_start[MAX_PROCS];
    logic [SIZE_W:0]   slot_len  [MAX_PROCS];
    logic [TIME_W-1:0] slot_tleft[MAX_PROCS];
    logic [SIZE_W:0]   free_units;
    logic [SIZE_W:0]   mem_units;
    rsp_item_t         awaited[$];
    int                errors;

    function void configure(logic [SIZE_W-1:0] v);
      mem_units = (v == 0) ? (SIZE_W+1)'(1)
                : ((v > MEM_MAX) ? (SIZE_W+1)'(MEM_MAX) : (SIZE_W+1)'(v));
      foreach (slot_used[i]) slot_used[i] = 0;
      free_units = mem_units;
    endfunction

    function int by_address(ref int ord[MAX_PROCS]);
      int n, v, b;
      n = 0;
      for (int i = 0; i < MAX_PROCS; i++) if (slot_used[i]) ord[n++] = i;
      for (int a = 1; a < n; a++) begin
        v = ord[a];
        b = a;
        while (b > 0 && slot_start[ord[b-1]] > slot_start[v]) begin
          ord[b] = ord[b-1];
          b--;
        end
        ord[b] = v;
      end
      return n;
    endfunction

    function int owner_slot(logic [ID_W-1:0] id);
      for (int i = 0; i < MAX_PROCS; i++) if (slot_used[i] && slot_owner[i] == id) return i;
      return -1;
    endfunction

    function logic [ID_W-1:0] live_id();
      int c[$];
      for (int i = 0; i < MAX_PROCS; i++) if (slot_used[i]) c.push_back(i);
      if (c.size() == 0) return ID_W'($urandom_range(0, 40));
      return slot_owner[c[$urandom_range(0, c.size() - 1)]];
    endfunction

    function void expect_rsp(status_t st, logic [SIZE_W:0] addr, logic [ID_W-1:0] eid,
                             bit fin);
      rsp_item_t r;
      logic [SIZE_W:0] top, used;
      top = 0;
      used = 0;
      for (int i = 0; i < MAX_PROCS; i++) if (slot_used[i]) begin
        used += slot_len[i];
        if (slot_start[i] + slot_len[i] > top) top = slot_start[i] + slot_len[i];
      end
      r.status = st;
      r.address = addr[ADDR_BITS-1:0];
      r.expired_id = eid;
      r.free_space = free_units[SIZE_W-1:0];
      r.compacted = (used == top);
      r.last = fin;
      awaited.push_back(r);
    endfunction

    function void note_request(req_item_t q);
      int ord[MAX_PROCS];
      int n, slot, s;
      logic [SIZE_W:0] cur, gap, best_sz, best_at, lim;
      bit found;
      logic [ID_W-1:0] gone[$];
      case (q.kind)
        REQ_ALLOC: begin
          if (owner_slot(q.id) >= 0) begin
            expect_rsp(STAT_DUP, 0, 0, 1);
            return;
          end
          slot = -1;
          for (int i = MAX_PROCS - 1; i >= 0; i--) if (!slot_used[i]) slot = i;
          if (slot < 0 || q.size == 0) begin
            expect_rsp(STAT_NOSPACE, 0, 0, 1);
            return;
          end
          n = by_address(ord);
          cur = 0;
          found = 0;
          best_sz = 0;
          best_at = 0;
          for (int k = 0; k <= n; k++) begin
            lim = (k < n) ? slot_start[ord[k]] : mem_units;
            gap = lim - cur;
            if (gap >= (SIZE_W+1)'(q.size) && (!found || gap < best_sz)) begin
              found = 1;
              best_sz = gap;
              best_at = cur;
            end
            if (k < n) cur = slot_start[ord[k]] + slot_len[ord[k]];
          end
          if (!found) begin
            expect_rsp(STAT_NOSPACE, 0, 0, 1);
            return;
          end
          slot_used[slot] = 1;
          slot_owner[slot] = q.id;
          slot_start[slot] = best_at;
          slot_len[slot] = (SIZE_W+1)'(q.size);
          slot_tleft[slot] = q.life;
          free_units -= (SIZE_W+1)'(q.size);
          expect_rsp(STAT_OK, best_at, 0, 1);
        end
        REQ_FREE: begin
          s = owner_slot(q.id);
          if (s < 0) begin
            expect_rsp(STAT_NOTFOUND, 0, 0, 1);
          end else begin
            slot_used[s] = 0;
            free_units += slot_len[s];
            expect_rsp(STAT_OK, 0, 0, 1);
          end
        end
        REQ_COMPACT: begin
          n = by_address(ord);
          cur = 0;
          for (int k = 0; k < n; k++) begin
            slot_start[ord[k]] = cur;
            cur += slot_len[ord[k]];
          end
          expect_rsp(STAT_OK, 0, 0, 1);
        end
        default: begin
          n = by_address(ord);
          for (int k = 0; k < n; k++) begin
            if (q.tick >= slot_tleft[ord[k]]) begin
              slot_used[ord[k]] = 0;
              free_units += slot_len[ord[k]];
              gone.push_back(slot_owner[ord[k]]);
            end else begin
              slot_tleft[ord[k]] -= q.tick;
            end
          end
          foreach (gone[k]) expect_rsp(STAT_OK, 0, gone[k], 0);
          expect_rsp(STAT_OK, 0, 0, 1);
        end
      endcase
    endfunction

    function void check_result(rsp_item_t got);
      rsp_item_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected response, status %0d", $time, got.status);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.address !== e.address) begin
        $display("%0t: address exp %0h got %0h", $time, e.address, got.address);
        errors++;
      end
      if (got.expired_id !== e.expired_id) begin
        $display("%0t: expired_id exp %0h got %0h", $time, e.expired_id, got.expired_id);
        errors++;
      end
      if (got.free_space !== e.free_space) begin
        $display("%0t: free_space exp %0h got %0h", $time, e.free_space, got.free_space);
        errors++;
      end
      if (got.compacted !== e.compacted) begin
        $display("%0t: compacted exp %0b got %0b", $time, e.compacted, got.compacted);
        errors++;
      end
      if (got.last !== e.last) begin
        $display("%0t: last exp %0b got %0b", $time, e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 3000;

  logic clk;
  logic rst;
  bfma_cfg_if cfg ();
  bfma_req_if req ();
  bfma_rsp_if rsp ();

  best_fit_memory_allocator u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg.sink),
    .req (req.sink),
    .rsp (rsp.source)
  );

  alloc_scoreboard sb = new();
  bit  steady_drain;
  int  drain_stall;
  int  quiet_cycles;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_item_t got;
    if (rst) begin
      rsp.ready <= 0;
      drain_stall <= 0;
    end else if (rsp.valid && rsp.ready) begin
      got.status = status_t'(rsp.status);
      got.address = rsp.address;
      got.expired_id = rsp.expired_id;
      got.free_space = rsp.free_space;
      got.compacted = rsp.compacted;
      got.last = rsp.last;
      sb.check_result(got);
      if (!steady_drain) begin
        drain_stall = $urandom_range(0, 7);
        if (drain_stall != 0) rsp.ready <= 0;
      end
    end else if (!rsp.ready) begin
      if (drain_stall <= 1) rsp.ready <= 1;
      drain_stall--;
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_best_fit_memory_allocator: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(logic [1:0] kind, logic [ID_W-1:0] id, logic [SIZE_W-1:0] size,
                              logic [TIME_W-1:0] life, logic [TIME_W-1:0] tick);
    req_item_t q;
    int gap;
    q.kind = kind;
    q.id = id;
    q.size = size;
    q.life = life;
    q.tick = tick;
    req.valid <= 1;
    req.req_type <= kind;
    req.proc_id <= id;
    req.proc_size <= size;
    req.lifetime <= life;
    req.tick_amount <= tick;
    do @(posedge clk); while (!req.ready);
    sb.note_request(q);
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    req.valid <= 0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_memory_size(logic [SIZE_W-1:0] v);
    cfg.valid <= 1;
    cfg.memory_size <= v;
    do @(posedge clk); while (!cfg.ready);
    sb.configure(v);
    cfg.valid <= 0;
    @(posedge clk);
  endtask

  task automatic random_requests(int count);
    int pick, top;
    logic [SIZE_W-1:0] sz;
    logic [TIME_W-1:0] life, tick;
    logic [ID_W-1:0] id;
    for (int k = 0; k < count; k++) begin
      top = (sb.mem_units > 8) ? int'(sb.mem_units) / 8 : 1;
      pick = $urandom_range(0, 99);
      sz = SIZE_W'($urandom_range(1, top));
      if (pick % 10 == 0) sz = 0;
      else if (pick % 10 == 1) sz = SIZE_W'($urandom);
      else if (pick % 10 == 2) sz = sb.mem_units[SIZE_W-1:0];
      life = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 50);
      tick = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 20);
      id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 40));
      if (pick < 45) send_request(REQ_ALLOC, id, sz, life, $urandom);
      else if (pick < 70)
        send_request(REQ_FREE, ($urandom_range(0, 3) != 0) ? sb.live_id() : id,
                     SIZE_W'($urandom), $urandom, $urandom);
      else if (pick < 80)
        send_request(REQ_COMPACT, ID_W'($urandom), SIZE_W'($urandom), $urandom, $urandom);
      else send_request(REQ_TICK, ID_W'($urandom), SIZE_W'($urandom), $urandom, tick);
    end
  endtask

  initial begin
    rst = 1;
    steady_drain = 0;
    quiet_cycles = 0;
    cfg.valid = 0;
    cfg.memory_size = 0;
    req.valid = 0;
    req.req_type = REQ_ALLOC;
    req.proc_id = 0;
    req.proc_size = 0;
    req.lifetime = 0;
    req.tick_amount = 0;
    rsp.ready = 0;
    sb.configure(MEM_MAX);
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_request(REQ_ALLOC, 16'hFFFF, MEM_MAX, 32'hFFFF_FFFF, 0);
    send_request(REQ_ALLOC, 1, 1, 5, 0);
    send_request(REQ_ALLOC, 16'hFFFF, 1, 5, 0);
    send_request(REQ_FREE, 16'hFFFF, 0, 0, 0);
    send_request(REQ_FREE, 7, 0, 0, 0);
    send_request(REQ_ALLOC, 0, 0, 5, 0);
    send_request(REQ_ALLOC, 1, 100, 0, 0);
    send_request(REQ_ALLOC, 2, 50, 10, 0);
    send_request(REQ_ALLOC, 3, 200, 5, 0);
    send_request(REQ_FREE, 2, 0, 0, 0);
    send_request(REQ_ALLOC, 4, 30, 9, 0);
    send_request(REQ_COMPACT, 0, 0, 0, 0);
    send_request(REQ_TICK, 0, 0, 0, 0);
    send_request(REQ_TICK, 0, 0, 0, 5);
    send_request(REQ_ALLOC, 5, {SIZE_W{1'b1}}, 1, 0);
    send_request(REQ_TICK, 0, 0, 0, 32'hFFFF_FFFF);

    for (int i = 0; i <= MAX_PROCS; i++)
      send_request(REQ_ALLOC, 16'(100 + i), 1, 32'hFFFF_FFF0, 0);
    send_request(REQ_TICK, 0, 0, 0, 32'hFFFF_FFFF);
    random_requests(10);
    settle();
    steady_drain = 1;
    random_requests(10);
    steady_drain = 0;
    settle();

    write_memory_size(64);
    random_requests(15);
    settle();
    write_memory_size(0);
    random_requests(5);
    settle();
    write_memory_size({SIZE_W{1'b1}});
    random_requests(10);
    settle();
    write_memory_size(200);
    random_requests(10);
    settle();
    write_memory_size(1);
    random_requests(10);
    settle();

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("tb_best_fit_memory_allocator: done, clean");
    end else begin
      $display("tb_best_fit_memory_allocator: done, errors");
    end
    $finish;
  end
endmodule
